FILE: sv/tccw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_pkg: shared types and codes of the text console character writer
// Command codes, character codes, register indexes and the item formats that
// pass from the command front end through the queue to the store engine.
// ----------------------------------------------------------------------------
package tccw_pkg;

    localparam logic [1:0] FUNC_PUT   = 2'd0;
    localparam logic [1:0] FUNC_SET   = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_ATTR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_TOP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_BOT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AUTOSCROLL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_EN  = 3'd4;
    localparam int CFG_DATA_W = 8;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] char_code;
        logic [6:0] set_col;
        logic [5:0] set_row;
        logic [7:0] fill_attribute;
    } t_cmd;

    typedef struct packed {
        logic        write_valid;
        logic [6:0]  write_col;
        logic [5:0]  write_row;
        logic [15:0] write_value;
        logic        display_write;
        logic [6:0]  cursor_col;
        logic [5:0]  cursor_row;
        logic        refresh_needed;
        logic        write_dropped;
    } t_result;

    // One queued item: the finished result plus the store work it implies.
    typedef struct packed {
        t_result     res;
        logic        do_scroll;
        logic        do_clear;
        logic [5:0]  top;
        logic [6:0]  lim;
        logic [6:0]  lines;
        logic [15:0] fill_value;
    } t_op;

endpackage

FILE: sv/tccw_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_front: command front end
// Holds the configuration registers and the cursor, decodes each command and
// builds the result plus the store work (cell write, scroll, clear).
// ----------------------------------------------------------------------------
module tccw_front #(
    parameter int COLUMNS  = 80,
    parameter int LINES    = 50,
    parameter int TAB_STOP = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wen,
    input  logic [tccw_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tccw_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_accept,
    input  tccw_pkg::t_cmd                 i_cmd,
    output tccw_pkg::t_op                  o_entry
);
    import tccw_pkg::*;

    localparam logic [6:0]  LastCol  = 7'(COLUMNS - 1);
    localparam logic [6:0]  LinesV   = 7'(LINES);
    localparam logic [6:0]  LastRow  = 7'(LINES - 1);
    localparam logic [11:0] ColLimit = 12'(COLUMNS);
    // floor(col / TAB_STOP) as (col * TabMul) >> 12, exact for col below 128
    localparam int          TabMul   = 4096 / TAB_STOP + 1;

    typedef struct packed {
        logic       hit;
        logic       moves;
        logic [6:0] new_row;
        logic [6:0] lines;
    } t_scroll;

    logic [7:0] r_attr;
    logic [5:0] r_top;
    logic [5:0] r_bottom;
    logic       r_autoscroll;
    logic       r_display;
    logic [6:0] r_col, n_col;
    logic [6:0] r_row, n_row;

    logic [6:0]  lim;
    logic [6:0]  inc_row;
    logic [18:0] tab_prod;
    logic [11:0] tab_next;
    t_scroll     scr;
    logic [6:0]  pos_col, pos_row;
    logic        do_write, use_scr, clear, wvalid, dropped;
    logic [15:0] wval;

    function automatic t_scroll scroll_eval(input logic [6:0] row, input logic [6:0] lmt,
                                            input logic [5:0] top, input logic en);
        t_scroll    s;
        logic [6:0] span;
        s.hit = 1'b0;
        s.moves = 1'b0;
        s.new_row = row;
        s.lines = 7'd0;
        span = lmt - {1'b0, top};
        if (en && (row >= lmt)) begin
            s.hit = 1'b1;
            s.lines = row - lmt + 7'd1;
            if ({1'b0, top} < lmt) begin
                s.moves = 1'b1;
                if (s.lines > span) begin
                    s.lines = span;
                end
            end
            s.new_row = lmt - 7'd1;
        end
        return s;
    endfunction

    always_comb begin
        if ({1'b0, r_bottom} > LinesV) begin
            lim = LinesV;
        end else if (r_bottom == 6'd0) begin
            lim = 7'd1;
        end else begin
            lim = {1'b0, r_bottom};
        end
        inc_row  = (r_row < LinesV) ? r_row + 7'd1 : r_row;
        tab_prod = 19'(r_col) * 19'(TabMul);
        tab_next = 12'(({5'd0, tab_prod[18:12]} + 12'd1) * 12'(TAB_STOP));
        scr      = scroll_eval(inc_row, lim, r_top, r_autoscroll);
    end

    always_comb begin
        n_col    = r_col;
        n_row    = r_row;
        pos_col  = r_col;
        pos_row  = r_row;
        do_write = 1'b0;
        use_scr  = 1'b0;
        clear    = 1'b0;
        wval     = 16'd0;
        case (i_cmd.func)
            FUNC_PUT: begin
                case (i_cmd.char_code)
                    CH_BACKSPACE: begin
                        if (r_col != 7'd0) begin
                            n_col = r_col - 7'd1;
                        end else if (r_row != 7'd0) begin
                            n_col = LastCol;
                            n_row = r_row - 7'd1;
                        end
                        pos_col  = n_col;
                        pos_row  = n_row;
                        do_write = 1'b1;
                        wval     = {r_attr, CH_SPACE};
                    end
                    CH_TAB: begin
                        if (tab_next >= ColLimit) begin
                            n_col   = 7'd0;
                            use_scr = 1'b1;
                        end else begin
                            n_col = tab_next[6:0];
                        end
                    end
                    CH_CR: begin
                        n_col = 7'd0;
                    end
                    CH_LF: begin
                        n_col   = 7'd0;
                        use_scr = 1'b1;
                    end
                    CH_NUL: begin
                    end
                    default: begin
                        do_write = 1'b1;
                        wval     = {r_attr, i_cmd.char_code};
                        if (r_col == LastCol) begin
                            n_col   = 7'd0;
                            use_scr = 1'b1;
                        end else begin
                            n_col = r_col + 7'd1;
                        end
                    end
                endcase
            end
            FUNC_SET: begin
                n_col = (i_cmd.set_col > LastCol) ? LastCol : i_cmd.set_col;
                n_row = ({1'b0, i_cmd.set_row} > LastRow) ? LastRow : {1'b0, i_cmd.set_row};
            end
            FUNC_CLEAR: begin
                n_col = 7'd0;
                n_row = 7'd0;
                clear = 1'b1;
            end
            default: begin
            end
        endcase
        if (use_scr) begin
            n_row = scr.new_row;
        end
        wvalid  = do_write && (pos_row < LinesV);
        dropped = do_write && !wvalid;
    end

    always_comb begin
        o_entry.res.write_valid    = wvalid;
        o_entry.res.write_col      = wvalid ? pos_col : 7'd0;
        o_entry.res.write_row      = wvalid ? pos_row[5:0] : 6'd0;
        o_entry.res.write_value    = wvalid ? wval : 16'd0;
        o_entry.res.display_write  = wvalid && r_display;
        o_entry.res.cursor_col     = n_col;
        o_entry.res.cursor_row     = n_row[5:0];
        o_entry.res.refresh_needed = ((use_scr && scr.hit) || clear) && r_display;
        o_entry.res.write_dropped  = dropped;
        o_entry.do_scroll          = use_scr && scr.hit && scr.moves;
        o_entry.do_clear           = clear;
        o_entry.top                = r_top;
        o_entry.lim                = lim;
        o_entry.lines              = scr.lines;
        o_entry.fill_value         = clear ? {i_cmd.fill_attribute, CH_SPACE} : {r_attr, CH_NUL};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr       <= 8'd7;
            r_top        <= 6'd0;
            r_bottom     <= 6'd39;
            r_autoscroll <= 1'b1;
            r_display    <= 1'b1;
            r_col        <= 7'd0;
            r_row        <= 7'd0;
        end else begin
            if (i_cfg_wen) begin
                case (i_cfg_index)
                    CFG_TEXT_ATTR:  r_attr       <= i_cfg_data;
                    CFG_SCROLL_TOP: r_top        <= i_cfg_data[5:0];
                    CFG_SCROLL_BOT: r_bottom     <= i_cfg_data[5:0];
                    CFG_AUTOSCROLL: r_autoscroll <= i_cfg_data[0];
                    CFG_DISPLAY_EN: r_display    <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (i_accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

endmodule

FILE: sv/tccw_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_queue: short queue between front end and store engine
// Register FIFO of decoded items; push and pop may happen in one cycle.
// ----------------------------------------------------------------------------
module tccw_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tccw_pkg::t_op i_entry,
    input  logic          i_pop,
    output tccw_pkg::t_op o_entry,
    output logic          o_full,
    output logic          o_empty
);
    import tccw_pkg::*;

    localparam logic [QUEUE_AW-1:0] LastPtr = QUEUE_AW'(QUEUE_DEPTH - 1);

    t_op                 r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wptr, r_rptr;
    logic [QUEUE_AW:0]   r_count;
    logic                do_push, do_pop;

    assign o_full  = (r_count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_entry = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == LastPtr) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == LastPtr) ? '0 : r_rptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: sv/tccw_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_back: cell store engine
// Owns the cell store, performs cell writes, scroll copies and fill sweeps,
// and holds the result register seen on the output side.
// ----------------------------------------------------------------------------
module tccw_back #(
    parameter int COLUMNS = 80,
    parameter int LINES   = 50
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    input  tccw_pkg::t_op     i_q_entry,
    output logic              o_q_pop,
    input  logic              i_pop,
    output logic              o_empty,
    output tccw_pkg::t_result o_res,
    output logic              o_init_busy
);
    import tccw_pkg::*;

    localparam int DEPTH = COLUMNS * LINES;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] LastAddr = AW'(DEPTH - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SETUP = 3'd1;
    localparam logic [2:0] S_COPY  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_FILL  = 3'd4;

    logic [15:0]   r_store [DEPTH];
    logic [2:0]    r_state;
    logic          r_init;
    logic          r_out_valid;
    t_result       r_out;
    t_op           r_op;
    logic [AW-1:0] r_dst, r_src, r_fill_start, r_end, r_wr_addr;
    logic [15:0]   r_val, r_rdata;
    logic          r_pend;

    logic          we;
    logic [AW-1:0] waddr;
    logic [15:0]   wdata;

    assign o_q_pop     = (r_state == S_IDLE) && !i_q_empty && (!r_out_valid || i_pop);
    assign o_empty     = !r_out_valid;
    assign o_res       = r_out;
    assign o_init_busy = r_init;

    always_comb begin
        we    = 1'b0;
        waddr = r_dst;
        wdata = r_val;
        case (r_state)
            S_IDLE: begin
                we    = o_q_pop && i_q_entry.res.write_valid;
                waddr = AW'(32'(i_q_entry.res.write_row) * COLUMNS
                            + 32'(i_q_entry.res.write_col));
                wdata = i_q_entry.res.write_value;
            end
            S_COPY, S_DRAIN: begin
                we    = r_pend;
                waddr = r_wr_addr;
                wdata = r_rdata;
            end
            S_FILL: begin
                we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_store[waddr] <= wdata;
        end
        r_rdata <= r_store[r_src];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FILL;
            r_init      <= 1'b1;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
            r_dst       <= '0;
            r_end       <= LastAddr;
            r_val       <= 16'd0;
        end else begin
            if (o_q_pop) begin
                r_out       <= i_q_entry.res;
                r_out_valid <= 1'b1;
                r_op        <= i_q_entry;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_q_pop) begin
                        if (i_q_entry.do_clear) begin
                            r_dst   <= '0;
                            r_end   <= LastAddr;
                            r_val   <= i_q_entry.fill_value;
                            r_state <= S_FILL;
                        end else if (i_q_entry.do_scroll) begin
                            r_state <= S_SETUP;
                        end
                    end
                end
                S_SETUP: begin
                    // fill rows [top, lim-lines) from the rows lines further down, then blank [lim-lines, lim)
                    r_dst        <= AW'(32'(r_op.top) * COLUMNS);
                    r_src        <= AW'((32'(r_op.top) + 32'(r_op.lines)) * COLUMNS);
                    r_fill_start <= AW'((32'(r_op.lim) - 32'(r_op.lines)) * COLUMNS);
                    r_end        <= AW'(32'(r_op.lim) * COLUMNS - 1);
                    r_val        <= r_op.fill_value;
                    r_state      <= (r_op.lim - r_op.lines > {1'b0, r_op.top}) ? S_COPY
                                                                               : S_FILL;
                end
                S_COPY: begin
                    r_src     <= r_src + 1'b1;
                    r_wr_addr <= r_dst;
                    r_pend    <= 1'b1;
                    r_dst     <= r_dst + 1'b1;
                    if (r_dst + 1'b1 == r_fill_start) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_pend  <= 1'b0;
                    r_state <= S_FILL;
                end
                S_FILL: begin
                    if (r_dst == r_end) begin
                        r_init  <= 1'b0;
                        r_state <= S_IDLE;
                    end else begin
                        r_dst <= r_dst + 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_no_pop_in_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_init |-> !o_q_pop)
        else $error("queue popped during store initialization");

    a_pend_scope: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_state == S_COPY || r_state == S_DRAIN))
        else $error("pending copy write outside copy sweep");

    a_copy_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COPY) |-> (r_src > r_dst))
        else $error("scroll copy source not ahead of destination");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL) |-> (r_dst <= r_end))
        else $error("fill sweep ran past its end");

endmodule

FILE: sv/text_console_char_writer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_char_writer: text console cell store and cursor
// Usage:
//   Commands enter on a queue-style port: an item is taken at a clock edge
//   with push high and full low. Results leave the same way: while empty is
//   low the oldest result is on the o_ result ports, taken when pop is high.
//   Configuration is written through i_cfg_wen / i_cfg_index / i_cfg_data;
//   the user must write it only while the block is idle; the block does not
//   enforce this. Plain characters, cursor moves and control codes sustain
//   one item per cycle, and the store engine one cell write per cycle from a
//   two-entry command queue, while pop drains results and no scroll or clear
//   keeps the engine busy. A scroll keeps it busy while it copies rows up
//   within scroll_top..limit and blanks the freed rows, where limit is
//   scroll_bottom kept within 1..LINES; a clear keeps it busy while it fills
//   the store. Both walks write one cell per cycle through the single store
//   write port. While the store is zeroed after reset, full stays high. If
//   the receiver stalls, one result is held and the queue fills, after which
//   full rises until pop drains it.
// ----------------------------------------------------------------------------
module text_console_char_writer #(
    parameter int COLUMNS  = 80,
    parameter int LINES    = 50,
    parameter int TAB_STOP = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wen,
    input  logic [tccw_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tccw_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           push,
    output logic                           full,
    input  logic [1:0]                     i_func,
    input  logic [7:0]                     i_char_code,
    input  logic [6:0]                     i_set_col,
    input  logic [5:0]                     i_set_row,
    input  logic [7:0]                     i_fill_attribute,
    output logic                           empty,
    input  logic                           pop,
    output logic                           o_write_valid,
    output logic [6:0]                     o_write_col,
    output logic [5:0]                     o_write_row,
    output logic [15:0]                    o_write_value,
    output logic                           o_display_write,
    output logic [6:0]                     o_cursor_col,
    output logic [5:0]                     o_cursor_row,
    output logic                           o_refresh_needed,
    output logic                           o_write_dropped
);
    import tccw_pkg::*;

    t_cmd    cmd;
    t_op     front_entry, q_entry;
    t_result res;
    logic    accept, q_full, q_empty, q_pop, init_busy;

    assign cmd.func           = i_func;
    assign cmd.char_code      = i_char_code;
    assign cmd.set_col        = i_set_col;
    assign cmd.set_row        = i_set_row;
    assign cmd.fill_attribute = i_fill_attribute;

    assign full   = q_full || init_busy;
    assign accept = push && !full;

    tccw_front #(
        .COLUMNS  (COLUMNS),
        .LINES    (LINES),
        .TAB_STOP (TAB_STOP)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_cmd       (cmd),
        .o_entry     (front_entry)
    );

    tccw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_entry (front_entry),
        .i_pop   (q_pop),
        .o_entry (q_entry),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    tccw_back #(
        .COLUMNS (COLUMNS),
        .LINES   (LINES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_entry   (q_entry),
        .o_q_pop     (q_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_res       (res),
        .o_init_busy (init_busy)
    );

    assign o_write_valid    = res.write_valid;
    assign o_write_col      = res.write_col;
    assign o_write_row      = res.write_row;
    assign o_write_value    = res.write_value;
    assign o_display_write  = res.display_write;
    assign o_cursor_col     = res.cursor_col;
    assign o_cursor_row     = res.cursor_row;
    assign o_refresh_needed = res.refresh_needed;
    assign o_write_dropped  = res.write_dropped;

endmodule
